[rtl/core/bag_pkg.sv]
`timescale 1ns / 1ps
package bag_pkg;
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] REG_GAP_OPEN = 2'd0;
  localparam logic [1:0] REG_GAP_EXT = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;
  localparam logic [1:0] REG_START = 2'd3;

  // one classified item in the queue
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] base;
    logic [7:0] ref_base;
    logic [7:0] quality;
    logic [23:0] match_score;
    logic [23:0] mismatch_score;
    logic last;
  } bag_item_t;
endpackage

[rtl/core/bag_front.sv]
`timescale 1ns / 1ps
module bag_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  bag_pkg::bag_item_t in_item,
  output logic q_valid,
  input  logic q_ready,
  output bag_pkg::bag_item_t q_item
);
  import bag_pkg::*;

  // two-entry queue, unused opcodes dropped at the door
  bag_item_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready && (in_item.op != OP_NONE);
  assign pop = q_valid && q_ready;
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[rtl/core/bag_back.sv]
`timescale 1ns / 1ps
module bag_back #(
  parameter int BAND_MAX = 16,
  parameter int QUAL_DEPTH = 256,
  parameter int SCORE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  bag_pkg::bag_item_t q_item,
  input  logic signed [SCORE_BITS-1:0] gap_open,
  input  logic signed [SCORE_BITS-1:0] gap_ext,
  input  logic [3:0] shift_cap,
  input  logic [3:0] max_start,
  output logic out_valid,
  input  logic out_ready,
  output logic [23:0] best_score,
  output logic unreachable,
  output logic busy
);
  import bag_pkg::*;

  localparam int Slots = 2 * BAND_MAX + 1;
  localparam int IdxW = $clog2(Slots + 1);
  localparam int QW = $clog2(QUAL_DEPTH);
  localparam logic signed [SCORE_BITS-1:0] Floor = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic signed [SCORE_BITS-1:0] Ceil = {1'b0, {(SCORE_BITS-1){1'b1}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;

  function automatic logic signed [SCORE_BITS-1:0] sadd(
    input logic signed [SCORE_BITS-1:0] a, input logic signed [SCORE_BITS-1:0] b);
    logic signed [SCORE_BITS:0] s;
    s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
    if (a == Floor || b == Floor) return Floor;
    if (s[SCORE_BITS] != s[SCORE_BITS-1]) return s[SCORE_BITS] ? Floor : Ceil;
    return s[SCORE_BITS-1:0];
  endfunction

  function automatic logic signed [SCORE_BITS-1:0] mx(
    input logic signed [SCORE_BITS-1:0] a, input logic signed [SCORE_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [SCORE_BITS-1:0] sat24(input logic [23:0] v);
    logic signed [SCORE_BITS+23:0] w;
    w = {{SCORE_BITS{v[23]}}, v};
    if (w < $signed({{24{Floor[SCORE_BITS-1]}}, Floor})) return Floor;
    if (w > $signed({{24{1'b0}}, Ceil})) return Ceil;
    return w[SCORE_BITS-1:0];
  endfunction

  // reference window ring, newest base at head
  logic [7:0] win [Slots];
  // score tables
  logic signed [SCORE_BITS-1:0] mt_mem [QUAL_DEPTH];
  logic signed [SCORE_BITS-1:0] mm_mem [QUAL_DEPTH];
  logic signed [SCORE_BITS-1:0] mt, mm;
  // rows (previous row values, updated in place going upward)
  logic signed [SCORE_BITS-1:0] ng_row [Slots];
  logic signed [SCORE_BITS-1:0] rd_row [Slots];
  logic signed [SCORE_BITS-1:0] rf_row [Slots];

  logic [1:0] state;
  logic in_read, first_row, is_last;
  logic [IdxW-1:0] idx;
  logic [7:0] rbase;
  logic [3:0] band, start;
  logic signed [SCORE_BITS-1:0] ng_prev, rd_prev, rf_prev, best;
  logic [23:0] best_r;
  logic unr_r;

  logic [3:0] band_c, start_c;
  assign band_c = (32'(shift_cap) > BAND_MAX - 1) ? 4'(BAND_MAX - 1) : shift_cap;
  assign start_c = (max_start > band_c) ? band_c : max_start;

  assign q_ready = (state == ST_IDLE);
  assign busy = (state != ST_IDLE) || in_read;
  assign best_score = best_r;
  assign unreachable = unr_r;

  // window ring pointer
  logic shift_in;
  logic [IdxW-1:0] head, head_next;
  assign shift_in = (state == ST_IDLE) && q_valid && q_ready &&
                    (q_item.op == OP_PUSH || q_item.op == OP_STEP);
  assign head_next = (head == '0) ? IdxW'(Slots - 1) : head - 1'b1;

  // registered row read-ahead and window tap
  logic signed [SCORE_BITS-1:0] ng_or, rd_or, rf_or, ng_ur, rd_ur, rf_ur;
  logic [IdxW:0] ahead, tap_age, tap_sum;
  logic [IdxW-1:0] tap_off, tap_addr, idx1;
  logic [7:0] wref;

  // cell i: signed shift s = i - BAND_MAX
  logic signed [IdxW+1:0] s_c;
  logic in_band;
  logic signed [SCORE_BITS-1:0] ng_o, rd_o, rf_o, ng_i, rd_i, rf_i;
  logic signed [SCORE_BITS-1:0] ng_u, rd_u, rf_u, sc;

  assign ahead = {1'b0, idx} + (IdxW+1)'(2);

  // window age for the next shift to be swept: band - s
  always_comb begin
    tap_off = (state == ST_FETCH) ? '0 : idx1;
    tap_age = (IdxW+1)'(band) + (IdxW+1)'(BAND_MAX) - {1'b0, tap_off};
    tap_sum = {1'b0, head} + tap_age;
    tap_addr = (tap_sum >= (IdxW+1)'(Slots)) ? IdxW'(tap_sum - (IdxW+1)'(Slots)) :
                                                tap_sum[IdxW-1:0];
  end

  always_comb begin
    idx1 = idx + 1'b1;
    s_c = $signed({2'b00, idx}) - (IdxW+2)'(BAND_MAX);
    in_band = (s_c >= -$signed({{(IdxW-2){1'b0}}, band})) &&
              (s_c <= $signed({{(IdxW-2){1'b0}}, band})) &&
              (idx != '0) && (32'(idx) < Slots - 1);
    // start row values, otherwise stored row
    if (first_row) begin
      ng_o = ((s_c >= -$signed({{(IdxW-2){1'b0}}, start})) &&
              (s_c <= $signed({{(IdxW-2){1'b0}}, start}))) ? '0 : Floor;
      rd_o = Floor;
      rf_o = Floor;
      ng_u = ((($signed({2'b00, idx1}) - (IdxW+2)'(BAND_MAX)) >=
               -$signed({{(IdxW-2){1'b0}}, start})) &&
              (($signed({2'b00, idx1}) - (IdxW+2)'(BAND_MAX)) <=
               $signed({{(IdxW-2){1'b0}}, start}))) ? '0 : Floor;
      rd_u = Floor;
      rf_u = Floor;
    end else begin
      ng_o = ng_or;
      rd_o = rd_or;
      rf_o = rf_or;
      ng_u = ng_ur;
      rd_u = rd_ur;
      rf_u = rf_ur;
    end
    sc = (in_band && rbase == wref) ? mt : mm;
    ng_i = mx(mx(sadd(ng_o, sc), sadd(rf_o, sc)), sadd(rd_o, sc));
    rd_i = mx(mx(sadd(ng_u, gap_open), sadd(rf_u, gap_open)), sadd(rd_u, gap_ext));
    rf_i = mx(mx(sadd(ng_prev, gap_open), sadd(rf_prev, gap_ext)), sadd(rd_prev, gap_open));
    if (!in_band) begin
      ng_i = Floor;
      rd_i = Floor;
      rf_i = Floor;
    end
  end

  // table memories: written on load, read once per step
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_ready && q_item.op == OP_LOAD) begin
      mt_mem[q_item.quality[QW-1:0]] <= sat24(q_item.match_score);
      mm_mem[q_item.quality[QW-1:0]] <= sat24(q_item.mismatch_score);
    end
    if (state == ST_IDLE && q_valid && q_ready && q_item.op == OP_STEP) begin
      mt <= mt_mem[q_item.quality[QW-1:0]];
      mm <= mm_mem[q_item.quality[QW-1:0]];
    end
  end

  // window ring, one entry written per push or step
  always_ff @(posedge clk) begin
    if (shift_in) win[head_next] <= (q_item.op == OP_PUSH) ? q_item.base : q_item.ref_base;
  end

  always_ff @(posedge clk) begin
    if (rst) head <= '0;
    else if (shift_in) head <= head_next;
  end

  // window tap, one shift ahead of the sweep
  always_ff @(posedge clk) begin
    if (tap_age < (IdxW+1)'(Slots)) wref <= win[tap_addr];
  end

  // row read-ahead: entries idx and idx+1 of the previous row
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      ng_or <= ng_row[0];
      rd_or <= rd_row[0];
      rf_or <= rf_row[0];
      ng_ur <= ng_row[1];
      rd_ur <= rd_row[1];
      rf_ur <= rf_row[1];
    end else if (state == ST_SWEEP) begin
      ng_or <= ng_ur;
      rd_or <= rd_ur;
      rf_or <= rf_ur;
      if (ahead < (IdxW+1)'(Slots)) begin
        ng_ur <= ng_row[ahead[IdxW-1:0]];
        rd_ur <= rd_row[ahead[IdxW-1:0]];
        rf_ur <= rf_row[ahead[IdxW-1:0]];
      end else begin
        ng_ur <= Floor;
        rd_ur <= Floor;
        rf_ur <= Floor;
      end
    end
  end

  // row update, one shift per cycle from the low end
  always_ff @(posedge clk) begin
    if (state == ST_SWEEP) begin
      ng_row[idx] <= ng_i;
      rd_row[idx] <= rd_i;
      rf_row[idx] <= rf_i;
      ng_prev <= ng_i;
      rd_prev <= rd_i;
      rf_prev <= rf_i;
      best <= mx(best, mx(ng_i, mx(rd_i, rf_i)));
    end else if (state != ST_OUT) begin
      ng_prev <= Floor;
      rd_prev <= Floor;
      rf_prev <= Floor;
      best <= Floor;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      in_read <= 1'b0;
      first_row <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_ready && q_item.op == OP_STEP) begin
            rbase <= q_item.base;
            is_last <= q_item.last;
            band <= band_c;
            start <= start_c;
            first_row <= !in_read;
            in_read <= 1'b1;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          idx <= '0;
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (32'(idx) == Slots - 1) begin
            first_row <= 1'b0;
            state <= is_last ? ST_OUT : ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_valid) begin
            best_r <= 24'(best);
            unr_r <= (best == Floor);
            out_valid <= 1'b1;
            in_read <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/banded_affine_gap_align_score_core.sv]
`timescale 1ns / 1ps
// push and table load beats are taken from the queue while the back end is idle; a
// read step goes through a fetch state and then sweeps the band, one band shift per cycle
// through the shared cell update; the last step's sweep is followed by the output state
// that raises the result beat. Beats are taken one per cycle only while it is idle;
// a result beat left waiting holds the back end in its output state
// reset: synchronous, clears queue, sequencer, read flag and configuration registers to defaults
module banded_affine_gap_align_score_core #(
  parameter int BAND_MAX = 16,
  parameter int QUAL_DEPTH = 256,
  parameter int SCORE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation[1:0], base[9:2], ref_base[17:10], quality[25:18],
  // match_score[49:26], mismatch_score[73:50], zero pad
  input  logic [79:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // best_score[23:0]
  output logic [23:0] m_axis_tdata,
  // unreachable
  output logic m_axis_tuser,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import bag_pkg::*;

  localparam logic signed [SCORE_BITS-1:0] Floor = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic signed [SCORE_BITS-1:0] Ceil = {1'b0, {(SCORE_BITS-1){1'b1}}};

  function automatic logic signed [SCORE_BITS-1:0] sat24(input logic [23:0] v);
    logic signed [SCORE_BITS+23:0] w;
    w = {{SCORE_BITS{v[23]}}, v};
    if (w < $signed({{24{Floor[SCORE_BITS-1]}}, Floor})) return Floor;
    if (w > $signed({{24{1'b0}}, Ceil})) return Ceil;
    return w[SCORE_BITS-1:0];
  endfunction

  logic signed [SCORE_BITS-1:0] gap_open, gap_ext;
  logic [3:0] shift_cap, max_start;
  bag_item_t in_item, q_item;
  logic q_valid, q_ready, busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_open <= sat24(24'hFFF6CA);
      gap_ext <= sat24(24'hFFFDB3);
      shift_cap <= 4'd8;
      max_start <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAP_OPEN: gap_open <= sat24(cfg_data);
        REG_GAP_EXT: gap_ext <= sat24(cfg_data);
        REG_SHIFT: shift_cap <= cfg_data[3:0];
        REG_START: max_start <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // unpack the input beat
  always_comb begin
    in_item.op = s_axis_tdata[1:0];
    in_item.base = s_axis_tdata[9:2];
    in_item.ref_base = s_axis_tdata[17:10];
    in_item.quality = s_axis_tdata[25:18];
    in_item.match_score = s_axis_tdata[49:26];
    in_item.mismatch_score = s_axis_tdata[73:50];
    in_item.last = s_axis_tlast;
  end

  bag_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  bag_back #(.BAND_MAX(BAND_MAX), .QUAL_DEPTH(QUAL_DEPTH), .SCORE_BITS(SCORE_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .gap_open(gap_open), .gap_ext(gap_ext),
    .shift_cap(shift_cap), .max_start(max_start),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .best_score(m_axis_tdata), .unreachable(m_axis_tuser), .busy(busy)
  );

`ifndef SYNTH
  // unreachable flag agrees with the floor score
  a_unr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata == 24'h800000) || SCORE_BITS != 24))
    else $error("unreachable flag mismatch");
  // a result only appears while a read is under way
  a_res: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(busy))
    else $error("result without a read");
  // after a queue handoff, a result never rises while the back end is not busy
  a_q: assert property (@(posedge clk) disable iff (rst)
    (q_ready && q_valid) |=> !(m_axis_tvalid && $rose(m_axis_tvalid) && !busy))
    else $error("queue handoff fault");
`endif
endmodule
